@@ rtl/ratio_sort_two_group_split_top_macros.svh @@
// Assertion macros for the ratio sort block.
`ifndef RATIO_SORT_TWO_GROUP_SPLIT_TOP_MACROS_SVH
`define RATIO_SORT_TWO_GROUP_SPLIT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define RS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define RS_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define RS_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ rtl/rssplit_pkg.sv @@
// Package for the ratio sort block: sizes and controller states.
package rssplit_pkg;
    localparam int MAX_ITEMS = 32;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IDW = 16;
    localparam int RW = 32;
    localparam int EW = IDW + RW;
    localparam logic [RW-1:0] RATIO_SAT = '1;

    typedef enum logic [3:0] {
        ST_LOAD, ST_DIV, ST_WR, ST_SRD, ST_SCMP, ST_SWR, ST_STAIL,
        ST_MINRD, ST_MINWT, ST_CRD, ST_CCMP, ST_HDR, ST_ORD, ST_OWT, ST_OUT
    } t_state;

    typedef enum logic {KIND_COUNT = 1'b0, KIND_ID = 1'b1} t_kind;
endpackage

@@ rtl/rssplit_ram.sv @@
// Generic single-port synchronous RAM with registered read.
module rssplit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ rtl/rssplit_div.sv @@
// Restoring Q16.16 divider, one quotient bit per cycle.
module rssplit_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_num,
    input  logic [15:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [47:0] r_num;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [16:0] n_shift;
    logic [17:0] n_diff;

    assign n_shift = {r_rem[15:0], r_num[47]};
    assign n_diff  = {1'b0, n_shift} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_num  <= {16'd0, i_num, 16'd0};
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_num <= {r_num[46:0], ~n_diff[17]};
                r_rem <= n_diff[17] ? n_shift : n_diff[16:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    // quotient bits above 32 are always zero since num < 2^16
    assign o_quot = (r_den == 16'd0) ? rssplit_pkg::RATIO_SAT : r_num[31:0];
endmodule

@@ rtl/ratio_sort_two_group_split_top.sv @@
// Ratio sort and two-group split: loads records, bubble sorts them in RAM, emits groups.
// Each record waits on the 48-step serial divider before it is stored. After the last
// record the bubble sort runs its passes through one RAM port (n*(n-1)/2 compares),
// then a counting pass over the entries, then the results are emitted. No input is
// taken while a set is sorted or emitted.
`include "ratio_sort_two_group_split_top_macros.svh"
module ratio_sort_two_group_split_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sample_id,
    input  logic [15:0] i_count_before,
    input  logic [15:0] i_count_after,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_entry_kind,
    output logic        o_group_sel,
    output logic [15:0] o_out_value,
    output logic        o_last_result
);
    localparam int AW = rssplit_pkg::AW;
    localparam int CW = rssplit_pkg::CW;
    localparam int EW = rssplit_pkg::EW;

    rssplit_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt;     // loaded count
    logic [CW-1:0] r_n;       // set size for the run
    logic [15:0]   r_id;
    logic          r_last;
    logic [AW-1:0] r_k, r_lim;  // bubble index / pass limit
    logic [EW-1:0] r_prev;
    logic [31:0]   r_max, r_min;
    logic [CW-1:0] r_strong;
    logic [CW-1:0] r_i;       // count / output index
    logic          r_grp;
    logic          r_ov;
    logic          r_okind, r_ogrp, r_olast;
    logic [15:0]   r_oval;

    logic          div_start, div_done;
    logic [31:0]   div_q;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [EW-1:0] ram_wd, ram_rd;
    logic          acc;
    logic [32:0]   sum;
    logic [CW-1:0] strong_end;
    logic          out_load;

    assign acc = i_valid && o_ready;
    assign sum = {1'b0, r_max} + {1'b0, r_min};
    assign strong_end = r_grp ? r_strong : '0;
    assign out_load = (!r_ov || i_ready) &&
                      ((r_state == rssplit_pkg::ST_HDR) ||
                       (r_state == rssplit_pkg::ST_OUT && !r_olast));

    rssplit_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(i_count_after), .i_den(i_count_before),
        .o_done(div_done), .o_quot(div_q)
    );

    rssplit_ram #(.WIDTH(EW), .DEPTH(rssplit_pkg::MAX_ITEMS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wd), .o_rdata(ram_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rssplit_pkg::ST_LOAD: if (acc) begin
                if (r_cnt < CW'(rssplit_pkg::MAX_ITEMS)) n_state = rssplit_pkg::ST_DIV;
                else if (i_last_item) n_state = rssplit_pkg::ST_SRD;
            end
            rssplit_pkg::ST_DIV: if (div_done) n_state = rssplit_pkg::ST_WR;
            rssplit_pkg::ST_WR: n_state = r_last ? rssplit_pkg::ST_SRD : rssplit_pkg::ST_LOAD;
            rssplit_pkg::ST_SRD:
                n_state = (r_n < CW'(2)) ? rssplit_pkg::ST_MINRD : rssplit_pkg::ST_SCMP;
            rssplit_pkg::ST_SCMP: n_state = rssplit_pkg::ST_SWR;
            rssplit_pkg::ST_SWR:
                if (r_k == r_lim) n_state = rssplit_pkg::ST_STAIL;
                else n_state = rssplit_pkg::ST_SCMP;
            rssplit_pkg::ST_STAIL:
                n_state = (r_lim == AW'(1)) ? rssplit_pkg::ST_MINRD : rssplit_pkg::ST_SRD;
            rssplit_pkg::ST_MINRD: n_state = rssplit_pkg::ST_MINWT;
            rssplit_pkg::ST_MINWT: n_state = rssplit_pkg::ST_CRD;
            rssplit_pkg::ST_CRD:
                n_state = (r_i == r_n) ? rssplit_pkg::ST_HDR : rssplit_pkg::ST_CCMP;
            rssplit_pkg::ST_CCMP: n_state = rssplit_pkg::ST_CRD;
            rssplit_pkg::ST_HDR: if (!r_ov || i_ready) n_state = rssplit_pkg::ST_ORD;
            rssplit_pkg::ST_ORD:
                if (r_i == strong_end) begin
                    if (r_grp) n_state = rssplit_pkg::ST_OUT;
                    else n_state = rssplit_pkg::ST_HDR;
                end else n_state = rssplit_pkg::ST_OWT;
            rssplit_pkg::ST_OWT: n_state = rssplit_pkg::ST_OUT;
            rssplit_pkg::ST_OUT:
                if (!r_ov || i_ready)
                    n_state = r_olast ? rssplit_pkg::ST_LOAD : rssplit_pkg::ST_ORD;
            default: n_state = rssplit_pkg::ST_LOAD;
        endcase
    end

    // outputs / datapath controls
    always_comb begin
        o_ready   = (r_state == rssplit_pkg::ST_LOAD) && !r_ov;
        div_start = (r_state == rssplit_pkg::ST_LOAD) && acc &&
                    (r_cnt < CW'(rssplit_pkg::MAX_ITEMS));
        ram_we    = 1'b0;
        ram_addr  = r_k;
        ram_wd    = r_prev;
        case (r_state)
            rssplit_pkg::ST_WR: begin
                ram_we   = 1'b1;
                ram_addr = r_cnt[AW-1:0];
                ram_wd   = {div_q, r_id};
            end
            rssplit_pkg::ST_SRD: ram_addr = '0;
            rssplit_pkg::ST_SCMP: ram_addr = r_k;
            rssplit_pkg::ST_SWR: begin
                // write the larger of the pair into k-1
                ram_addr = r_k - AW'(1);
                ram_we   = 1'b1;
                ram_wd   = (ram_rd[EW-1:16] > r_prev[EW-1:16]) ? ram_rd : r_prev;
            end
            // carried survivor lands at the end of the pass
            rssplit_pkg::ST_STAIL: ram_we = 1'b1;
            rssplit_pkg::ST_MINRD: ram_addr = AW'(r_n - CW'(1));
            rssplit_pkg::ST_CRD: ram_addr = r_i[AW-1:0];
            // hold the address so the read data stays put while the output stalls
            rssplit_pkg::ST_ORD: ram_addr = AW'(r_i - CW'(1));
            rssplit_pkg::ST_OWT: ram_addr = AW'(r_i - CW'(1));
            rssplit_pkg::ST_OUT: ram_addr = AW'(r_i - CW'(1));
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rssplit_pkg::ST_LOAD;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            case (r_state)
                rssplit_pkg::ST_LOAD: if (acc) begin
                    r_id   <= i_sample_id;
                    r_last <= i_last_item;
                    if (!(r_cnt < CW'(rssplit_pkg::MAX_ITEMS)) && i_last_item) begin
                        r_n   <= r_cnt;
                        r_cnt <= '0;
                        r_k   <= AW'(1);
                        r_lim <= AW'(r_cnt - CW'(1));
                    end
                end
                rssplit_pkg::ST_WR: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_last) begin
                        r_n   <= r_cnt + CW'(1);
                        r_cnt <= '0;
                        r_k   <= AW'(1);
                        r_lim <= AW'(r_cnt);
                    end
                end
                rssplit_pkg::ST_SRD: begin
                    r_i <= '0;
                end
                rssplit_pkg::ST_SCMP: begin
                    if (r_k == AW'(1)) r_prev <= ram_rd;  // element 0 just read
                end
                rssplit_pkg::ST_SWR: begin
                    // carry larger-index survivor: the smaller ratio moves down, stable
                    logic [EW-1:0] hi;
                    hi = (ram_rd[EW-1:16] > r_prev[EW-1:16]) ? r_prev : ram_rd;
                    if (r_k != r_lim) r_k <= r_k + AW'(1);
                    r_prev <= hi;
                end
                rssplit_pkg::ST_STAIL: begin
                    r_k   <= AW'(1);
                    r_lim <= r_lim - AW'(1);
                end
                rssplit_pkg::ST_MINWT: begin
                    r_min <= ram_rd[EW-1:16];
                    r_strong <= '0;
                    r_i <= '0;
                end
                rssplit_pkg::ST_CCMP: begin
                    if (r_i == '0) r_max <= ram_rd[EW-1:16];
                    if ({ram_rd[EW-1:16], 1'b0} >= ((r_i == '0) ?
                            {1'b0, ram_rd[EW-1:16]} + {1'b0, r_min} : sum))
                        r_strong <= r_strong + CW'(1);
                    r_i <= r_i + CW'(1);
                end
                rssplit_pkg::ST_CRD: if (r_i == r_n) begin
                    r_grp <= 1'b0;
                end
                rssplit_pkg::ST_HDR: if (!r_ov || i_ready) begin
                    r_okind <= rssplit_pkg::KIND_COUNT;
                    r_ogrp  <= r_grp;
                    r_oval  <= 16'(r_grp ? (r_n - r_strong) : r_strong);
                    r_olast <= r_grp && (r_n == r_strong);
                    r_i     <= r_grp ? r_n : r_strong;
                end
                rssplit_pkg::ST_ORD: if (r_i == strong_end && !r_grp) r_grp <= 1'b1;
                rssplit_pkg::ST_OWT: ;
                rssplit_pkg::ST_OUT: if (!r_ov || i_ready) begin
                    if (!r_olast) begin
                        r_okind <= rssplit_pkg::KIND_ID;
                        r_ogrp  <= r_grp;
                        r_oval  <= ram_rd[15:0];
                        r_olast <= r_grp && (r_i - CW'(1) == r_strong);
                        r_i     <= r_i - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_entry_kind  = r_okind;
    assign o_group_sel   = r_ogrp;
    assign o_out_value   = r_oval;
    assign o_last_result = r_olast;

    `RS_ASSERT_IMP(a_no_in_during_out, i_clk, i_rst_n, o_valid, !o_ready)
    `RS_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(rssplit_pkg::MAX_ITEMS))
    `RS_ASSERT_NXT(a_last_done, i_clk, i_rst_n, o_valid && i_ready && o_last_result,
                   !o_valid)
endmodule

@@ test/tb.sv @@
// Testbench for ratio_sort_two_group_split_top: random record sets checked against a predictor.
`timescale 1ns / 1ps
module tb;
    typedef struct packed {
        logic        kind;
        logic        grp;
        logic [15:0] value;
        logic        last;
    } t_entry;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_sample_id;
    logic [15:0] i_count_before;
    logic [15:0] i_count_after;
    logic        i_last_item;
    logic        o_valid;
    logic        i_ready;
    logic        o_entry_kind;
    logic        o_group_sel;
    logic [15:0] o_out_value;
    logic        o_last_result;

    // predictor state
    logic [15:0] set_ids[rssplit_pkg::MAX_ITEMS];
    logic [31:0] set_ratios[rssplit_pkg::MAX_ITEMS];
    int          set_len;
    t_entry      pending_entries[$];

    int mismatch_count;
    int burst_left;
    int hold_off_cycles;
    bit stall_enable;

    ratio_sort_two_group_split_top dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [31:0] q16_div(logic [15:0] after_cnt, logic [15:0] before_cnt);
        logic [47:0] num;
        if (before_cnt == 16'd0) begin
            return rssplit_pkg::RATIO_SAT;
        end
        num = 48'({after_cnt, 16'd0});
        return 32'(num / before_cnt);
    endfunction

    // loads one record; on last, sorts, splits and queues the output sequence
    task automatic predict_record(logic [15:0] id, logic [15:0] bef, logic [15:0] aft,
                                  logic lst);
        logic [31:0] tr;
        logic [15:0] tid;
        logic [32:0] total;
        int          strong_cnt;
        if (set_len < rssplit_pkg::MAX_ITEMS) begin
            set_ids[set_len] = id;
            set_ratios[set_len] = q16_div(aft, bef);
            set_len++;
        end
        if (!lst) begin
            return;
        end
        for (int p = 0; p + 1 < set_len; p++) begin
            for (int k = 1; k < set_len - p; k++) begin
                if (set_ratios[k] > set_ratios[k-1]) begin
                    tr = set_ratios[k];
                    tid = set_ids[k];
                    set_ratios[k] = set_ratios[k-1];
                    set_ids[k] = set_ids[k-1];
                    set_ratios[k-1] = tr;
                    set_ids[k-1] = tid;
                end
            end
        end
        strong_cnt = 0;
        if (set_len > 0) begin
            total = {1'b0, set_ratios[0]} + {1'b0, set_ratios[set_len-1]};
            for (int i = 0; i < set_len; i++) begin
                if ({set_ratios[i], 1'b0} >= total) begin
                    strong_cnt++;
                end
            end
        end
        pending_entries.push_back('{rssplit_pkg::KIND_COUNT, 1'b0, 16'(strong_cnt), 1'b0});
        for (int i = strong_cnt; i > 0; i--) begin
            pending_entries.push_back('{rssplit_pkg::KIND_ID, 1'b0, set_ids[i-1], 1'b0});
        end
        pending_entries.push_back('{rssplit_pkg::KIND_COUNT, 1'b1, 16'(set_len - strong_cnt),
                                    set_len == strong_cnt});
        for (int i = set_len; i > strong_cnt; i--) begin
            pending_entries.push_back('{rssplit_pkg::KIND_ID, 1'b1, set_ids[i-1],
                                        i == strong_cnt + 1});
        end
        set_len = 0;
    endtask

    // leaves valid high on return; the next call or wait_drained takes it down
    task automatic send_record(logic [15:0] id, logic [15:0] bef, logic [15:0] aft,
                               logic lst, bit gaps = 1'b1);
        if (gaps) begin
            if (burst_left == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 60)) @(negedge i_clk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        i_valid <= 1'b1;
        i_sample_id <= id;
        i_count_before <= bef;
        i_count_after <= aft;
        i_last_item <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_record(id, bef, aft, lst);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_entries.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_random_set(int n, int flavor);
        logic [15:0] b;
        logic [15:0] a;
        for (int i = 0; i < n; i++) begin
            b = 16'($urandom);
            a = 16'($urandom);
            case (flavor)
                1: b = 16'($urandom_range(0, 3));
                2: begin
                    b = 16'd7;
                    a = 16'($urandom_range(0, 3) * 7);
                end
                default: if ($urandom_range(0, 9) == 0) b = 16'd0;
            endcase
            send_record(16'($urandom), b, a, i == n - 1);
        end
    endtask

    task automatic test_directed();
        // single record: strong group holds it, weak group empty
        send_record(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        // zero before, including zero after too
        send_record(16'h0000, 16'd0, 16'd0, 1'b0);
        send_record(16'h1234, 16'd0, 16'hFFFF, 1'b0);
        send_record(16'h8001, 16'd1, 16'd0, 1'b0);
        send_record(16'h7FFE, 16'd1, 16'hFFFF, 1'b1);
        // ties keep load order
        send_record(16'd1, 16'd3, 16'd1, 1'b0);
        send_record(16'd2, 16'd6, 16'd2, 1'b0);
        send_record(16'd3, 16'd9, 16'd3, 1'b0);
        send_record(16'd4, 16'd1, 16'd5, 1'b1);
        wait_drained();
    endtask

    task automatic test_store_full();
        // overflow records are dropped, the last still starts the run
        for (int i = 0; i < rssplit_pkg::MAX_ITEMS + 3; i++) begin
            send_record(16'(i + 100), 16'($urandom_range(0, 20)), 16'($urandom),
                        i == rssplit_pkg::MAX_ITEMS + 2);
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off_cycles = 3000;
        send_random_set(4, 0);
        send_random_set(3, 0);
        wait_drained();
    endtask

    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 260) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
            send_random_set(n, $urandom_range(0, 2));
            sent += n;
            if ($urandom_range(0, 5) == 0) begin
                wait_drained();
            end
        end
        wait_drained();
    endtask

    // receiver: own stall pattern, long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else if (stall_enable) begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_enable <= !stall_enable;
    end

    always @(posedge i_clk) begin
        t_entry want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_entries.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result kind=%0d grp=%0d val=%h last=%0d",
                             o_entry_kind, o_group_sel, o_out_value, o_last_result);
                end
            end else begin
                want = pending_entries.pop_front();
                if (want !== {o_entry_kind, o_group_sel, o_out_value, o_last_result}) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch exp kind=%0d grp=%0d val=%h last=%0d, ",
                                 want.kind, want.grp, want.value, want.last,
                                 "got kind=%0d grp=%0d val=%h last=%0d",
                                 o_entry_kind, o_group_sel, o_out_value, o_last_result);
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("ratio_sort_two_group_split_top verification failed");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_sample_id = '0;
        i_count_before = '0;
        i_count_after = '0;
        i_last_item = 1'b0;
        stall_enable = 1'b1;
        hold_off_cycles = 0;
        burst_left = 0;
        set_len = 0;
        mismatch_count = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_store_full();
        test_backpressure();
        test_random();
        repeat (200) @(negedge i_clk);
        if (mismatch_count == 0 && pending_entries.size() == 0) begin
            $display("ratio_sort_two_group_split_top verification clean");
        end else begin
            $display("ratio_sort_two_group_split_top verification failed");
        end
        $finish;
    end
endmodule
